[hdl/rms_pkg.sv]
// Shared types, constants and helpers for the robot mission sequencer
package rms_pkg;

   localparam int COUNT_BITS = 13;
   localparam int TICK_BITS  = 12;
   localparam int COORD_BITS = 16;
   localparam int CMP_BITS   = (COUNT_BITS > TICK_BITS + 1) ? COUNT_BITS : TICK_BITS + 1;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [TICK_BITS-1:0]  OBST_WAIT_RST   = TICK_BITS'(30);
   localparam logic [TICK_BITS-1:0]  REPLAN_DLY_RST  = TICK_BITS'(5);
   localparam logic [TICK_BITS-1:0]  ARRIVE_WAIT_RST = TICK_BITS'(30);
   localparam logic [COUNT_BITS-1:0] CNT_MAX         = {COUNT_BITS{1'b1}};

   typedef enum logic [2:0] {
      EV_GOAL     = 3'd0,
      EV_OBSTACLE = 3'd1,
      EV_PATH     = 3'd2,
      EV_ARRIVED  = 3'd3,
      EV_TICK     = 3'd4
   } event_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_OBST_WAIT   = 3'd0,
      CSR_REPLAN_DLY  = 3'd1,
      CSR_ARRIVE_WAIT = 3'd2,
      CSR_HOME_X      = 3'd3,
      CSR_HOME_Y      = 3'd4
   } csr_index_type;

   typedef enum logic [5:0] {
      ST_STANDBY   = 6'b000001,
      ST_DRIVING   = 6'b000010,
      ST_WAIT      = 6'b000100,
      ST_REPLAN    = 6'b001000,
      ST_ARRIVED   = 6'b010000,
      ST_RETURNING = 6'b100000
   } mission_state_type;

   localparam logic [2:0] CODE_STANDBY   = 3'd0;
   localparam logic [2:0] CODE_DRIVING   = 3'd1;
   localparam logic [2:0] CODE_WAIT      = 3'd2;
   localparam logic [2:0] CODE_REPLAN    = 3'd3;
   localparam logic [2:0] CODE_ARRIVED   = 3'd4;
   localparam logic [2:0] CODE_RETURNING = 3'd5;

   typedef struct packed {
      logic [TICK_BITS-1:0]         obstacle_wait_ticks;
      logic [TICK_BITS-1:0]         replan_delay_ticks;
      logic [TICK_BITS-1:0]         arrived_wait_ticks;
      logic signed [COORD_BITS-1:0] home_x_mm;
      logic signed [COORD_BITS-1:0] home_y_mm;
   } cfg_type;

   typedef struct packed {
      logic [2:0]                   state_code;
      logic [2:0]                   mode_code;
      logic                         mode_changed;
      logic                         home_goal;
      logic signed [COORD_BITS-1:0] goal_x;
      logic signed [COORD_BITS-1:0] goal_y;
   } rsp_type;

   function automatic logic [2:0] state_code(input mission_state_type st);
      logic [2:0] code;
      code = CODE_STANDBY;
      unique case (st)
         ST_STANDBY:   code = CODE_STANDBY;
         ST_DRIVING:   code = CODE_DRIVING;
         ST_WAIT:      code = CODE_WAIT;
         ST_REPLAN:    code = CODE_REPLAN;
         ST_ARRIVED:   code = CODE_ARRIVED;
         ST_RETURNING: code = CODE_RETURNING;
         default:      code = CODE_STANDBY;
      endcase
      return code;
   endfunction

endpackage

[hdl/robot_mission_sequencer.sv]
// Top level of the robot mission sequencer: input register, state machine, result register
// A request is captured in the input register; its result is offered from the result register.
// Throughput: one event per cycle while results are taken; the input and result registers advance together
// whenever the result register is empty or being taken.
// Reset (synchronous, active high): standby, no goal, obstacle level low, counter zero,
// configuration back to its defaults, both pipeline registers empty.
module robot_mission_sequencer (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic [2:0]                                req_func,
   input  logic                                      req_flag,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic [2:0]                                rsp_state_code,
   output logic [2:0]                                rsp_mode_code,
   output logic                                      rsp_mode_changed,
   output logic                                      rsp_home_goal,
   output logic signed [rms_pkg::COORD_BITS-1:0]     rsp_goal_x,
   output logic signed [rms_pkg::COORD_BITS-1:0]     rsp_goal_y,
   input  logic                                      csr_wr_en,
   input  logic [rms_pkg::CSR_IDX_BITS-1:0]          csr_index,
   input  logic [rms_pkg::CSR_DATA_BITS-1:0]         csr_wdata
);
   import rms_pkg::*;

   cfg_type    cfg;
   rsp_type    step_rsp;
   rsp_type    rsp_ff;
   logic       out_vld_ff, out_vld_in;
   logic       in_vld_ff, in_vld_in;
   logic [2:0] func_ff;
   logic       flag_ff;
   logic       advance;
   logic       req_xfer;

   assign advance    = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready  = !in_vld_ff || advance;
   assign req_xfer   = req_valid && req_ready;
   assign in_vld_in  = req_xfer || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && !rsp_ready);

   rms_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rms_fsm u_fsm (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .ev_func (func_ff),
      .ev_flag (flag_ff),
      .cfg     (cfg),
      .rsp     (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         func_ff <= req_func;
         flag_ff <= req_flag;
      end
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_state_code   = rsp_ff.state_code;
   assign rsp_mode_code    = rsp_ff.mode_code;
   assign rsp_mode_changed = rsp_ff.mode_changed;
   assign rsp_home_goal    = rsp_ff.home_goal;
   assign rsp_goal_x       = rsp_ff.goal_x;
   assign rsp_goal_y       = rsp_ff.goal_y;

endmodule

[hdl/rms_csr.sv]
// Configuration registers of the mission sequencer
module rms_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [rms_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [rms_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output rms_pkg::cfg_type                  cfg
);
   import rms_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_OBST_WAIT:   cfg_in.obstacle_wait_ticks = csr_wdata[TICK_BITS-1:0];
            CSR_REPLAN_DLY:  cfg_in.replan_delay_ticks  = csr_wdata[TICK_BITS-1:0];
            CSR_ARRIVE_WAIT: cfg_in.arrived_wait_ticks  = csr_wdata[TICK_BITS-1:0];
            CSR_HOME_X:      cfg_in.home_x_mm           = csr_wdata[COORD_BITS-1:0];
            CSR_HOME_Y:      cfg_in.home_y_mm           = csr_wdata[COORD_BITS-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.obstacle_wait_ticks <= OBST_WAIT_RST;
         cfg_ff.replan_delay_ticks  <= REPLAN_DLY_RST;
         cfg_ff.arrived_wait_ticks  <= ARRIVE_WAIT_RST;
         cfg_ff.home_x_mm           <= '0;
         cfg_ff.home_y_mm           <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hdl/rms_fsm.sv]
// Mission state machine, tick counter and per-event result logic
module rms_fsm (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  logic [2:0]       ev_func,
   input  logic             ev_flag,
   input  rms_pkg::cfg_type cfg,
   output rms_pkg::rsp_type rsp
);
   import rms_pkg::*;

   mission_state_type      state_ff, state_in;
   logic                   obst_ff, obst_in;
   logic                   goal_ff, goal_in;
   logic                   saved_ff, saved_in;
   logic [COUNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [COUNT_BITS-1:0]  cnt_inc;
   logic [TICK_BITS:0]     replan_limit;
   logic                   moving;
   logic                   home;
   logic [2:0]             code;

   assign moving       = (state_ff == ST_DRIVING) || (state_ff == ST_RETURNING);
   assign cnt_inc      = (cnt_ff == CNT_MAX) ? cnt_ff : cnt_ff + COUNT_BITS'(1);
   assign replan_limit = {1'b0, cfg.obstacle_wait_ticks} + {1'b0, cfg.replan_delay_ticks};

   always_comb begin
      state_in = state_ff;
      obst_in  = obst_ff;
      goal_in  = goal_ff;
      saved_in = saved_ff;
      cnt_in   = cnt_ff;
      home     = 1'b0;
      case (ev_func)
         EV_GOAL: begin
            goal_in = 1'b1;
            if ((state_ff == ST_STANDBY) || (state_ff == ST_ARRIVED)) begin
               state_in = ST_DRIVING;
            end
         end
         EV_OBSTACLE: begin
            obst_in = ev_flag;
            if (!obst_ff && ev_flag) begin
               if (moving) begin
                  saved_in = (state_ff == ST_RETURNING);
                  cnt_in   = '0;
                  state_in = ST_WAIT;
               end
            end else if (obst_ff && !ev_flag && (state_ff == ST_WAIT)) begin
               state_in = ST_REPLAN;
            end
         end
         EV_PATH: begin
            if (moving && ev_flag && goal_ff) begin
               goal_in  = 1'b0;
               state_in = ST_STANDBY;
            end
         end
         EV_ARRIVED: begin
            if (ev_flag && (state_ff == ST_DRIVING)) begin
               cnt_in   = '0;
               state_in = ST_ARRIVED;
            end else if (ev_flag && (state_ff == ST_RETURNING)) begin
               goal_in  = 1'b0;
               state_in = ST_STANDBY;
            end
         end
         EV_TICK: begin
            cnt_in = cnt_inc;
            if (state_ff == ST_REPLAN) begin
               if (CMP_BITS'(cnt_inc) >= CMP_BITS'(replan_limit)) begin
                  state_in = saved_ff ? ST_RETURNING : ST_DRIVING;
               end
            end else if (state_ff == ST_ARRIVED) begin
               if (CMP_BITS'(cnt_inc) > CMP_BITS'(cfg.arrived_wait_ticks)) begin
                  home     = 1'b1;
                  state_in = ST_RETURNING;
               end
            end
         end
         default: ;
      endcase
   end

   assign code = state_code(state_in);

   always_comb begin
      rsp.state_code   = code;
      rsp.mode_code    = (state_in == ST_REPLAN) ?
                         (saved_in ? CODE_RETURNING : CODE_DRIVING) : code;
      rsp.mode_changed = (state_in != state_ff);
      rsp.home_goal    = home;
      rsp.goal_x       = home ? cfg.home_x_mm : '0;
      rsp.goal_y       = home ? cfg.home_y_mm : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_STANDBY;
         obst_ff  <= 1'b0;
         goal_ff  <= 1'b0;
         saved_ff <= 1'b0;
         cnt_ff   <= '0;
      end else if (step_en) begin
         state_ff <= state_in;
         obst_ff  <= obst_in;
         goal_ff  <= goal_in;
         saved_ff <= saved_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[test/testbench.sv]
// Self-checking testbench for the robot mission sequencer, with its own state predictor
module testbench;
   import rms_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 4;
   localparam int END_WAIT     = 2000;
   localparam int FUNC_MAX     = (1 << 3) - 1;
   localparam int CSR_IDX_MAX  = (1 << CSR_IDX_BITS) - 1;
   localparam int MAX_REPORTS  = 10;
   localparam int PHASE_EVENTS = 200;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [2:0]                   req_func = '0;
   logic                         req_flag = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [2:0]                   rsp_state_code;
   logic [2:0]                   rsp_mode_code;
   logic                         rsp_mode_changed;
   logic                         rsp_home_goal;
   logic signed [COORD_BITS-1:0] rsp_goal_x;
   logic signed [COORD_BITS-1:0] rsp_goal_y;
   logic                         csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0]      csr_index = '0;
   logic [CSR_DATA_BITS-1:0]     csr_wdata = '0;

   robot_mission_sequencer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_flag         (req_flag),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_state_code   (rsp_state_code),
      .rsp_mode_code    (rsp_mode_code),
      .rsp_mode_changed (rsp_mode_changed),
      .rsp_home_goal    (rsp_home_goal),
      .rsp_goal_x       (rsp_goal_x),
      .rsp_goal_y       (rsp_goal_y),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #2 clock = ~clock;

   // predicted mission state and configuration
   logic [2:0]            mission = CODE_STANDBY;
   logic                  obst_level = 1'b0;
   logic                  goal_held = 1'b0;
   logic                  saved_returning = 1'b0;
   logic [COUNT_BITS-1:0] tick_count = '0;
   cfg_type               cfg_now;

   rsp_type pending_status[$];
   bit      calm = 1'b0;
   int      events_sent = 0;
   int      directed_events = 0;
   int      responses_checked = 0;
   int      home_goals_seen = 0;
   int      changes_seen = 0;
   int      mismatches = 0;
   int      cycles = 0;
   int      stall_left = 0;
   rsp_type got;
   rsp_type want;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic step_mission(input logic [2:0] func, input logic flag);
      rsp_type    status;
      logic [2:0] was;
      logic       moving;
      was = mission;
      moving = (mission == CODE_DRIVING) || (mission == CODE_RETURNING);
      status = '0;
      case (func)
         EV_GOAL: begin
            goal_held = 1'b1;
            if (mission == CODE_STANDBY || mission == CODE_ARRIVED) mission = CODE_DRIVING;
         end
         EV_OBSTACLE: begin
            if (!obst_level && flag && moving) begin
               saved_returning = (mission == CODE_RETURNING);
               tick_count = '0;
               mission = CODE_WAIT;
            end else if (obst_level && !flag && mission == CODE_WAIT) begin
               mission = CODE_REPLAN;
            end
            obst_level = flag;
         end
         EV_PATH: begin
            if (moving && flag && goal_held) begin
               goal_held = 1'b0;
               mission = CODE_STANDBY;
            end
         end
         EV_ARRIVED: begin
            if (flag && mission == CODE_DRIVING) begin
               tick_count = '0;
               mission = CODE_ARRIVED;
            end else if (flag && mission == CODE_RETURNING) begin
               goal_held = 1'b0;
               mission = CODE_STANDBY;
            end
         end
         EV_TICK: begin
            if (tick_count != CNT_MAX) tick_count = tick_count + 1'b1;
            if (mission == CODE_REPLAN) begin
               if (int'(tick_count) >= int'(cfg_now.obstacle_wait_ticks)
                                       + int'(cfg_now.replan_delay_ticks))
                  mission = saved_returning ? CODE_RETURNING : CODE_DRIVING;
            end else if (mission == CODE_ARRIVED) begin
               if (int'(tick_count) > int'(cfg_now.arrived_wait_ticks)) begin
                  status.home_goal = 1'b1;
                  status.goal_x = cfg_now.home_x_mm;
                  status.goal_y = cfg_now.home_y_mm;
                  mission = CODE_RETURNING;
               end
            end
         end
         default: ;
      endcase
      status.state_code = mission;
      status.mode_code = (mission == CODE_REPLAN) ?
                         (saved_returning ? CODE_RETURNING : CODE_DRIVING) : mission;
      status.mode_changed = (mission != was);
      pending_status.push_back(status);
   endtask

   // called at a rising edge; returns at the edge of the transfer
   task automatic send_event(input logic [2:0] func, input logic flag);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_func <= 3'($urandom_range(0, FUNC_MAX));
         req_flag <= rand_bit();
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_flag <= flag;
      do @(posedge clock); while (!req_ready);
      step_mission(func, flag);
      events_sent++;
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_OBST_WAIT:   cfg_now.obstacle_wait_ticks = data[TICK_BITS-1:0];
         CSR_REPLAN_DLY:  cfg_now.replan_delay_ticks = data[TICK_BITS-1:0];
         CSR_ARRIVE_WAIT: cfg_now.arrived_wait_ticks = data[TICK_BITS-1:0];
         CSR_HOME_X:      cfg_now.home_x_mm = data;
         CSR_HOME_Y:      cfg_now.home_y_mm = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_BITS-1:0] obst_wait,
                            input logic [CSR_DATA_BITS-1:0] replan_dly,
                            input logic [CSR_DATA_BITS-1:0] arrive_wait,
                            input logic [CSR_DATA_BITS-1:0] home_x,
                            input logic [CSR_DATA_BITS-1:0] home_y);
      wait_drain();
      write_reg(CSR_OBST_WAIT, obst_wait);
      write_reg(CSR_REPLAN_DLY, replan_dly);
      write_reg(CSR_ARRIVE_WAIT, arrive_wait);
      write_reg(CSR_HOME_X, home_x);
      write_reg(CSR_HOME_Y, home_y);
   endtask

   task automatic maybe_noise();
      if ($urandom_range(0, 99) < 20)
         repeat ($urandom_range(1, 3)) send_event(3'($urandom_range(0, FUNC_MAX)), rand_bit());
   endtask

   task automatic obstacle_episode();
      int k;
      int n;
      k = $urandom_range(0, 4);
      send_event(EV_OBSTACLE, 1'b1);
      repeat (k) send_event(EV_TICK, rand_bit());
      maybe_noise();
      send_event(EV_OBSTACLE, 1'b0);
      n = int'(cfg_now.obstacle_wait_ticks) + int'(cfg_now.replan_delay_ticks) - k
          + int'($urandom_range(0, 3)) - 1;
      if (n < 0) n = 0;
      repeat (n) send_event(EV_TICK, rand_bit());
   endtask

   task automatic run_mission();
      int n;
      maybe_noise();
      send_event(EV_GOAL, rand_bit());
      repeat ($urandom_range(0, 3)) send_event(EV_TICK, rand_bit());
      if ($urandom_range(0, 1)) obstacle_episode();
      maybe_noise();
      if ($urandom_range(0, 5) == 0) begin
         send_event(EV_PATH, 1'b1);
      end else begin
         send_event(EV_ARRIVED, 1'b1);
         n = int'(cfg_now.arrived_wait_ticks) + int'($urandom_range(0, 3));
         repeat (n) send_event(EV_TICK, rand_bit());
         if ($urandom_range(0, 1)) obstacle_episode();
         maybe_noise();
         send_event($urandom_range(0, 1) ? EV_ARRIVED : EV_PATH, 1'b1);
      end
   endtask

   // one full mission on the reset timings and home position
   task automatic test_reset_defaults();
      send_event(EV_GOAL, 1'b0);
      send_event(EV_OBSTACLE, 1'b1);
      repeat (3) send_event(EV_TICK, 1'b0);
      send_event(EV_OBSTACLE, 1'b0);
      repeat (33) send_event(EV_TICK, 1'b0);
      send_event(EV_ARRIVED, 1'b1);
      repeat (31) send_event(EV_TICK, 1'b1);
      send_event(EV_ARRIVED, 1'b1);
   endtask

   task automatic test_directed_events();
      configure('0, '0, '0, 16'h8000, 16'h7FFF);
      for (int f = int'(EV_TICK) + 1; f <= FUNC_MAX; f++) send_event(3'(f), rand_bit());
      send_event(EV_ARRIVED, 1'b0);
      send_event(EV_PATH, 1'b1);
      send_event(EV_TICK, 1'b1);
      send_event(EV_GOAL, 1'b1);
      send_event(EV_GOAL, 1'b0);
      send_event(EV_OBSTACLE, 1'b1);
      send_event(EV_OBSTACLE, 1'b1);
      send_event(EV_PATH, 1'b1);
      send_event(EV_OBSTACLE, 1'b0);
      send_event(EV_TICK, 1'b0);
      send_event(EV_ARRIVED, 1'b1);
      send_event(EV_GOAL, 1'b0);
      send_event(EV_ARRIVED, 1'b1);
      send_event(EV_TICK, 1'b0);
      send_event(EV_OBSTACLE, 1'b1);
      send_event(EV_OBSTACLE, 1'b0);
      send_event(EV_TICK, 1'b1);
      send_event(EV_PATH, 1'b0);
      send_event(EV_PATH, 1'b1);
      send_event(EV_GOAL, 1'b0);
      send_event(EV_ARRIVED, 1'b1);
      send_event(EV_TICK, 1'b0);
      send_event(EV_ARRIVED, 1'b1);
      directed_events = events_sent;
   endtask

   // writes to indexes beyond the register map must leave the timings alone
   task automatic test_unused_registers();
      wait_drain();
      for (int i = int'(CSR_HOME_Y) + 1; i <= CSR_IDX_MAX; i++)
         write_reg(CSR_IDX_BITS'(i), '1);
      send_event(EV_GOAL, 1'b0);
      send_event(EV_ARRIVED, 1'b1);
      send_event(EV_TICK, 1'b0);
      send_event(EV_ARRIVED, 1'b1);
   endtask

   task automatic test_random_missions();
      int start;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: configure(16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                         16'($urandom_range(0, 8)), 16'($urandom), 16'($urandom));
            1: configure('0, '0, '0, 16'h8000, 16'h7FFF);
            2: configure({4'($urandom), 12'($urandom_range(0, 9))},
                         {4'($urandom), 12'($urandom_range(0, 9))},
                         {4'($urandom), 12'($urandom_range(0, 9))}, 16'h7FFF, 16'h8000);
            default: configure(16'($urandom_range(1, 12)), 16'($urandom_range(0, 3)),
                               16'($urandom_range(1, 12)), 16'($urandom), 16'($urandom));
         endcase
         start = events_sent;
         while (events_sent - start < PHASE_EVENTS) begin
            calm = ($urandom_range(0, 4) == 0);
            run_mission();
         end
         calm = 1'b0;
      end
   endtask

   // long obstacle and dwell timers, counted out exactly
   task automatic test_long_timers();
      configure(16'd64, 16'd63, 16'd100, 16'($urandom), 16'($urandom));
      calm = 1'b1;
      send_event(EV_OBSTACLE, 1'b0);
      send_event(EV_GOAL, 1'b0);
      send_event(EV_ARRIVED, 1'b1);
      repeat (int'(cfg_now.arrived_wait_ticks) + 1) send_event(EV_TICK, rand_bit());
      send_event(EV_OBSTACLE, 1'b1);
      send_event(EV_OBSTACLE, 1'b0);
      repeat (int'(cfg_now.obstacle_wait_ticks) + int'(cfg_now.replan_delay_ticks))
         send_event(EV_TICK, rand_bit());
      send_event(EV_ARRIVED, 1'b1);
      calm = 1'b0;
   endtask

   task automatic finish_run();
      wait_drain();
      for (int c = 0; c < END_WAIT && pending_status.size() != 0; c++) @(posedge clock);
      if (pending_status.size() != 0) begin
         $display("%0d responses never arrived", pending_status.size());
         mismatches += pending_status.size();
      end
      $display("run: %0d events (%0d directed), %0d responses checked, %0d mismatches",
               events_sent, directed_events, responses_checked, mismatches);
      $display("run: %0d state changes, %0d home goals, long obstacle and dwell timers",
               changes_seen, home_goals_seen);
      if (mismatches == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   endtask

   // response check and receiver stalls
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got.state_code = rsp_state_code;
         got.mode_code = rsp_mode_code;
         got.mode_changed = rsp_mode_changed;
         got.home_goal = rsp_home_goal;
         got.goal_x = rsp_goal_x;
         got.goal_y = rsp_goal_y;
         responses_checked++;
         if (got.home_goal === 1'b1) home_goals_seen++;
         if (got.mode_changed === 1'b1) changes_seen++;
         if (pending_status.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) $display("unexpected response transfer");
         end else begin
            want = pending_status.pop_front();
            if (got.state_code !== want.state_code || got.mode_code !== want.mode_code ||
                got.mode_changed !== want.mode_changed || got.home_goal !== want.home_goal ||
                got.goal_x !== want.goal_x || got.goal_y !== want.goal_y) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"response %0d: want st %0d mode %0d chg %b home %b x %0d y %0d,",
                            " got st %0d mode %0d chg %b home %b x %0d y %0d"},
                           responses_checked, want.state_code, want.mode_code,
                           want.mode_changed, want.home_goal, want.goal_x, want.goal_y,
                           got.state_code, got.mode_code, got.mode_changed, got.home_goal,
                           got.goal_x, got.goal_y);
            end
         end
      end
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      cfg_now.obstacle_wait_ticks = OBST_WAIT_RST;
      cfg_now.replan_delay_ticks = REPLAN_DLY_RST;
      cfg_now.arrived_wait_ticks = ARRIVE_WAIT_RST;
      cfg_now.home_x_mm = '0;
      cfg_now.home_y_mm = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_events();
      test_unused_registers();
      test_random_missions();
      test_long_timers();
      finish_run();
   end

endmodule
